FILE: rtl/core/clps_pkg.sv
// ----------------------------------------------------------------------------
// clps_pkg
// Shared constants and command codes for the capacity limited path search.
// ----------------------------------------------------------------------------
package clps_pkg;
   localparam int MaxCities    = 64;
   localparam int MaxDegree    = 16;
   localparam int DistBits     = 16;
   localparam int CityBits     = $clog2(MaxCities);
   localparam int DegBits      = $clog2(MaxDegree);
   localparam int CntBits      = $clog2(MaxDegree + 1);
   localparam int DepthBits    = $clog2(MaxCities + 1);
   localparam int EdgeAddrBits = CityBits + DegBits;
   localparam int MatAddrBits  = 2 * CityBits;
   localparam int RefillBits   = 7;
   localparam int CountBits    = 7;

   typedef logic [1:0] cmd_type;
   localparam cmd_type CmdAdd   = 2'd0;
   localparam cmd_type CmdQuery = 2'd1;
   localparam cmd_type CmdClear = 2'd2;
endpackage

FILE: rtl/core/capacity_limited_path_search_unit.sv
// ----------------------------------------------------------------------------
// capacity_limited_path_search_unit
// Road graph store with depth-first capacity-limited path search and refills.
// ----------------------------------------------------------------------------
// Reset and clear zero the degree counts; an add appends the road at both ends.
// A query clears the visited marks, then walks the graph depth first, reading
// each adjacency slot, pushing when the road fits and backtracking at a list
// end, then counts refills along the path and offers one result per path city.
// One request at a time; results are held while rsp_stall is high.
// Synchronous active-high reset clears control state and starts the pass.
module capacity_limited_path_search_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [clps_pkg::CountBits-1:0]    csr_wdata,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  clps_pkg::cmd_type                 req_cmd,
   input  logic [clps_pkg::CityBits-1:0]     req_city_a,
   input  logic [clps_pkg::CityBits-1:0]     req_city_b,
   input  logic [clps_pkg::DistBits-1:0]     req_road_length,
   input  logic [clps_pkg::DistBits-1:0]     req_tank_capacity,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_possible,
   output logic [clps_pkg::RefillBits-1:0]   rsp_refills,
   output logic [clps_pkg::CityBits-1:0]     rsp_city,
   output logic                              rsp_last
);
   import clps_pkg::*;

   // sequencer states
   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_CLR    = 5'd1;   // zero one degree count per cycle
   localparam logic [4:0] S_ADD_A  = 5'd2;   // append at city a, matrix a->b
   localparam logic [4:0] S_ADD_RB = 5'd3;   // read degree of city b
   localparam logic [4:0] S_ADD_B  = 5'd4;   // append at city b, matrix b->a
   localparam logic [4:0] S_VCLR   = 5'd5;   // clear visited marks, mark start
   localparam logic [4:0] S_NODE   = 5'd6;   // read degree of top city
   localparam logic [4:0] S_SCAN   = 5'd7;   // read next slot or backtrack
   localparam logic [4:0] S_EDGE   = 5'd8;   // slot data back, check length
   localparam logic [4:0] S_VIS    = 5'd9;   // visited mark back, push or skip
   localparam logic [4:0] S_POP    = 5'd10;  // parent entry back
   localparam logic [4:0] S_RF_RD  = 5'd11;  // read next path city
   localparam logic [4:0] S_RF_MAT = 5'd12;  // read hop distance
   localparam logic [4:0] S_RF_AC  = 5'd13;  // burn fuel for the hop
   localparam logic [4:0] S_RF_FN  = 5'd14;  // final refill check
   localparam logic [4:0] S_EM_RD  = 5'd15;  // read path city for a result
   localparam logic [4:0] S_EMIT   = 5'd16;  // offer one path city
   localparam logic [4:0] S_FAIL   = 5'd17;  // offer the impossible result

   localparam int StkBits = CityBits + CntBits;
   localparam int EdgeBits = CityBits + DistBits;

   logic [4:0]            state_ff, state_in;
   logic [CountBits-1:0]  city_count_ff;

   // captured request
   logic [CityBits-1:0]   a_ff, a_in, b_ff, b_in;
   logic [DistBits-1:0]   len_ff, len_in, cap_ff, cap_in;

   // clearing pass index
   logic [CityBits-1:0]   clr_ff, clr_in;

   // top of stack kept in registers; entries below it live in stk_mem
   logic [CityBits-1:0]   node_ff, node_in;
   logic [CntBits-1:0]    cursor_ff, cursor_in;
   logic [DepthBits-1:0]  depth_ff, depth_in;

   // refill counting and result index
   logic [DepthBits-1:0]  k_ff, k_in;
   logic [CityBits-1:0]   prev_ff, prev_in;
   logic [DistBits+1:0]   left_ff, left_in;   // two's complement fuel left
   logic [RefillBits-1:0] fills_ff, fills_in;

   // memories: edge slots, pair matrix, stack, degree counts, visited marks
   logic [EdgeBits-1:0]   edge_mem [MaxCities*MaxDegree];
   logic [DistBits-1:0]   mat_mem  [MaxCities*MaxCities];
   logic [StkBits-1:0]    stk_mem  [MaxCities];
   logic [CntBits-1:0]    deg_mem  [MaxCities];
   logic                  vis_mem  [MaxCities];

   logic [EdgeBits-1:0]   edge_rd_ff;
   logic [DistBits-1:0]   mat_rd_ff;
   logic [StkBits-1:0]    stk_rd_ff;
   logic [CntBits-1:0]    deg_rd_ff;
   logic                  vis_rd_ff;

   logic                    e_we, e_re;
   logic [EdgeAddrBits-1:0] e_addr;
   logic [EdgeBits-1:0]     e_wd;
   logic                    m_we, m_re;
   logic [MatAddrBits-1:0]  m_addr;
   logic [DistBits-1:0]     m_wd;
   logic                    s_we, s_re;
   logic [CityBits-1:0]     s_waddr, s_raddr;
   logic [StkBits-1:0]      s_wd;
   logic                    d_we, d_re;
   logic [CityBits-1:0]     d_addr;
   logic [CntBits-1:0]      d_wd;
   logic                    v_we, v_re;
   logic [CityBits-1:0]     v_addr;
   logic                    v_wd;

   logic [CountBits-1:0] lim;
   assign lim = (city_count_ff < CountBits'(MaxCities)) ? city_count_ff
                                                        : CountBits'(MaxCities);

   assign req_stall = (state_ff != S_IDLE);
   wire req_fire = req_valid && !req_stall;

   wire a_ok = {1'b0, req_city_a} < lim;
   wire b_ok = {1'b0, req_city_b} < lim;

   // memory ports: one access per memory per cycle, registered read data
   always_ff @(posedge clock) begin
      if (e_we) edge_mem[e_addr] <= e_wd;
      if (e_re) edge_rd_ff <= edge_mem[e_addr];
      if (m_we) mat_mem[m_addr] <= m_wd;
      if (m_re) mat_rd_ff <= mat_mem[m_addr];
      if (s_we) stk_mem[s_waddr] <= s_wd;
      if (s_re) stk_rd_ff <= stk_mem[s_raddr];
      if (d_we) deg_mem[d_addr] <= d_wd;
      if (d_re) deg_rd_ff <= deg_mem[d_addr];
      if (v_we) vis_mem[v_addr] <= v_wd;
      if (v_re) vis_rd_ff <= vis_mem[v_addr];
   end

   wire [CityBits-1:0]  e_dst     = edge_rd_ff[EdgeBits-1:DistBits];
   wire [DistBits-1:0]  e_len     = edge_rd_ff[DistBits-1:0];
   wire [CityBits-1:0]  stk_city  = stk_rd_ff[StkBits-1:CntBits];
   wire [CntBits-1:0]   stk_cur   = stk_rd_ff[CntBits-1:0];
   wire [DepthBits-1:0] top_k     = depth_ff - DepthBits'(1);
   wire                 at_top    = (k_ff == top_k);
   wire                 deg_room  = deg_rd_ff < CntBits'(MaxDegree);
   wire [CityBits-1:0]  hop_city  = at_top ? b_ff : stk_city;
   wire [DistBits+1:0]  left_sub  = left_ff - {2'b00, mat_rd_ff};
   wire [DistBits+1:0]  left_rst  = {2'b00, cap_ff} - {2'b00, mat_rd_ff};

   always_comb begin
      state_in  = state_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      len_in    = len_ff;
      cap_in    = cap_ff;
      clr_in    = clr_ff;
      node_in   = node_ff;
      cursor_in = cursor_ff;
      depth_in  = depth_ff;
      k_in      = k_ff;
      prev_in   = prev_ff;
      left_in   = left_ff;
      fills_in  = fills_ff;
      e_we = 1'b0; e_re = 1'b0;
      e_addr = {node_ff, cursor_ff[DegBits-1:0]};
      e_wd   = {b_ff, len_ff};
      m_we = 1'b0; m_re = 1'b0; m_addr = {a_ff, b_ff}; m_wd = len_ff;
      s_we = 1'b0; s_re = 1'b0;
      s_waddr = CityBits'(top_k);
      s_raddr = CityBits'(k_ff);
      s_wd    = {node_ff, cursor_ff};
      d_we = 1'b0; d_re = 1'b0; d_addr = clr_ff; d_wd = '0;
      v_we = 1'b0; v_re = 1'b0; v_addr = clr_ff; v_wd = (clr_ff == a_ff);
      unique case (state_ff)
         S_IDLE: begin
            // prefetch the degree of city a with the request
            d_addr = req_city_a;
            d_re   = req_fire;
            if (req_fire) begin
               a_in      = req_city_a;
               b_in      = req_city_b;
               len_in    = req_road_length;
               cap_in    = req_tank_capacity;
               node_in   = req_city_a;
               cursor_in = '0;
               depth_in  = DepthBits'(1);
               k_in      = '0;
               fills_in  = RefillBits'(1);
               clr_in    = '0;
               unique case (req_cmd)
                  CmdAdd: begin
                     if (a_ok && b_ok) state_in = S_ADD_A;
                  end
                  CmdQuery: begin
                     if (!(a_ok && b_ok)) state_in = S_FAIL;
                     else if (req_city_a == req_city_b) state_in = S_EM_RD;
                     else state_in = S_VCLR;
                  end
                  CmdClear: begin
                     state_in = S_CLR;
                  end
                  default: ;  // drop unknown commands
               endcase
            end
         end
         S_CLR: begin
            d_we   = 1'b1;
            clr_in = clr_ff + CityBits'(1);
            if (clr_ff == '1) state_in = S_IDLE;
         end
         S_ADD_A: begin
            // drop the road at a full list; the matrix is written anyway
            e_we   = deg_room;
            e_addr = {a_ff, deg_rd_ff[DegBits-1:0]};
            e_wd   = {b_ff, len_ff};
            d_we   = deg_room;
            d_addr = a_ff;
            d_wd   = deg_rd_ff + CntBits'(1);
            m_we   = 1'b1;
            m_addr = {a_ff, b_ff};
            state_in = S_ADD_RB;
         end
         S_ADD_RB: begin
            // the count of a is written, so a self road sees its update
            d_re   = 1'b1;
            d_addr = b_ff;
            state_in = S_ADD_B;
         end
         S_ADD_B: begin
            e_we   = deg_room;
            e_addr = {b_ff, deg_rd_ff[DegBits-1:0]};
            e_wd   = {a_ff, len_ff};
            d_we   = deg_room;
            d_addr = b_ff;
            d_wd   = deg_rd_ff + CntBits'(1);
            m_we   = 1'b1;
            m_addr = {b_ff, a_ff};
            state_in = S_IDLE;
         end
         S_VCLR: begin
            // clear every mark except the start city's
            v_we   = 1'b1;
            clr_in = clr_ff + CityBits'(1);
            if (clr_ff == '1) state_in = S_NODE;
         end
         S_NODE: begin
            d_re   = 1'b1;
            d_addr = node_ff;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (cursor_ff < deg_rd_ff) begin
               e_re      = 1'b1;
               cursor_in = cursor_ff + CntBits'(1);
               state_in  = S_EDGE;
            end else if (depth_ff == DepthBits'(1)) begin
               state_in = S_FAIL;
            end else begin
               // backtrack: fetch the parent city and its saved cursor
               s_re     = 1'b1;
               s_raddr  = CityBits'(depth_ff - DepthBits'(2));
               depth_in = top_k;
               state_in = S_POP;
            end
         end
         S_EDGE: begin
            if (e_len <= cap_ff) begin
               v_re     = 1'b1;
               v_addr   = e_dst;
               state_in = S_VIS;
            end else state_in = S_SCAN;
         end
         S_VIS: begin
            if (!vis_rd_ff) begin
               // save the advanced cursor of the current top and push
               s_we     = 1'b1;
               v_we     = 1'b1;
               v_addr   = e_dst;
               v_wd     = 1'b1;
               depth_in = depth_ff + DepthBits'(1);
               if (e_dst == b_ff) begin
                  prev_in  = a_ff;
                  k_in     = DepthBits'(1);
                  left_in  = {2'b00, cap_ff};
                  fills_in = RefillBits'(1);
                  state_in = S_RF_RD;
               end else begin
                  node_in   = e_dst;
                  cursor_in = '0;
                  state_in  = S_NODE;
               end
            end else state_in = S_SCAN;
         end
         S_POP: begin
            node_in   = stk_city;
            cursor_in = stk_cur;
            state_in  = S_NODE;
         end
         S_RF_RD: begin
            // the destination is not in the stack memory; take it from b
            s_re     = !at_top;
            state_in = S_RF_MAT;
         end
         S_RF_MAT: begin
            m_re     = 1'b1;
            m_addr   = {prev_ff, hop_city};
            prev_in  = hop_city;
            state_in = S_RF_AC;
         end
         S_RF_AC: begin
            if (left_sub[DistBits+1]) begin
               left_in = left_rst;
               if (fills_ff != '1) fills_in = fills_ff + RefillBits'(1);
            end else left_in = left_sub;
            k_in = k_ff + DepthBits'(1);
            if (at_top) state_in = S_RF_FN;
            else state_in = S_RF_RD;
         end
         S_RF_FN: begin
            if (left_ff[DistBits+1] && fills_ff != '1)
               fills_in = fills_ff + RefillBits'(1);
            k_in     = '0;
            state_in = S_EM_RD;
         end
         S_EM_RD: begin
            s_re     = !at_top;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            // hold the result while stalled; advance after each accept
            if (!rsp_stall) begin
               if (at_top) state_in = S_IDLE;
               else begin
                  k_in     = k_ff + DepthBits'(1);
                  state_in = S_EM_RD;
               end
            end
         end
         S_FAIL: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLR;
         city_count_ff <= CountBits'(MaxCities);
         a_ff          <= '0;
         b_ff          <= '0;
         len_ff        <= '0;
         cap_ff        <= '0;
         clr_ff        <= '0;
         node_ff       <= '0;
         cursor_ff     <= '0;
         depth_ff      <= '0;
         k_ff          <= '0;
         prev_ff       <= '0;
         left_ff       <= '0;
         fills_ff      <= '0;
      end else begin
         state_ff  <= state_in;
         if (csr_we) city_count_ff <= csr_wdata;
         a_ff      <= a_in;
         b_ff      <= b_in;
         len_ff    <= len_in;
         cap_ff    <= cap_in;
         clr_ff    <= clr_in;
         node_ff   <= node_in;
         cursor_ff <= cursor_in;
         depth_ff  <= depth_in;
         k_ff      <= k_in;
         prev_ff   <= prev_in;
         left_ff   <= left_in;
         fills_ff  <= fills_in;
      end
   end

   // Results: the final path city is the destination, the others come from
   // the stack read issued in the cycle before the offer.
   assign rsp_valid    = (state_ff == S_EMIT) || (state_ff == S_FAIL);
   assign rsp_possible = (state_ff == S_EMIT);
   assign rsp_refills  = (state_ff == S_EMIT) ? fills_ff : '0;
   assign rsp_city     = (state_ff == S_EMIT) ? hop_city : '0;
   assign rsp_last     = (state_ff == S_FAIL) || ((state_ff == S_EMIT) && at_top);
endmodule

FILE: tb/sv/capacity_limited_path_search_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capacity_limited_path_search_unit_test
// Self-checking bench: random road graphs and path queries against a local
// depth-first search predictor, with random request gaps, random result
// stalls and city_count changes between phases.
// ----------------------------------------------------------------------------
module capacity_limited_path_search_unit_test;
   import clps_pkg::*;

   localparam cmd_type CmdUnused  = 2'd3;
   localparam int      WatchLimit = 20000;
   localparam int      ParkCycles = 300;
   localparam int      DrainGap   = 100;

   typedef struct {
      cmd_type     cmd;
      logic [5:0]  city_a;
      logic [5:0]  city_b;
      logic [15:0] road_length;
      logic [15:0] tank_capacity;
   } road_request_type;

   typedef struct {
      logic       possible;
      logic [6:0] refills;
      logic [5:0] city;
      logic       last;
   } path_step_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [6:0]  csr_wdata;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_cmd;
   logic [5:0]  req_city_a;
   logic [5:0]  req_city_b;
   logic [15:0] req_road_length;
   logic [15:0] req_tank_capacity;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_possible;
   logic [6:0]  rsp_refills;
   logic [5:0]  rsp_city;
   logic        rsp_last;

   capacity_limited_path_search_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_city_a        (req_city_a),
      .req_city_b        (req_city_b),
      .req_road_length   (req_road_length),
      .req_tank_capacity (req_tank_capacity),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_possible      (rsp_possible),
      .rsp_refills       (rsp_refills),
      .rsp_city          (rsp_city),
      .rsp_last          (rsp_last)
   );

   // Shadow copy of the road graph and the city_count register.
   logic [5:0]  road_dest [MaxCities][MaxDegree];
   logic [15:0] road_len  [MaxCities][MaxDegree];
   int          road_degree [MaxCities];
   logic [15:0] pair_dist [MaxCities][MaxCities];
   int          cities_in_use;

   road_request_type pending_requests[$];
   path_step_type    expected_steps[$];

   int req_accepts, rsp_accepts, mismatches, idle_cycles;
   int queries_seen, paths_found, impossible_seen, roads_seen;
   int park_requests, park_served;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Predict the path search for one accepted request.
   task automatic predict_request(input road_request_type rq);
      int             limit, depth, top, node, idx, nb, fills, k;
      int             path_city [MaxCities];
      int             path_cursor [MaxCities];
      bit             seen [MaxCities];
      bit             found, moved;
      longint         fuel, hop;
      path_step_type  step;
      limit = (cities_in_use < MaxCities) ? cities_in_use : MaxCities;
      case (rq.cmd)
         CmdAdd: begin
            if (rq.city_a < limit && rq.city_b < limit) begin
               roads_seen++;
               if (road_degree[rq.city_a] < MaxDegree) begin
                  road_dest[rq.city_a][road_degree[rq.city_a]] = rq.city_b;
                  road_len[rq.city_a][road_degree[rq.city_a]]  = rq.road_length;
                  road_degree[rq.city_a]++;
               end
               if (road_degree[rq.city_b] < MaxDegree) begin
                  road_dest[rq.city_b][road_degree[rq.city_b]] = rq.city_a;
                  road_len[rq.city_b][road_degree[rq.city_b]]  = rq.road_length;
                  road_degree[rq.city_b]++;
               end
               pair_dist[rq.city_a][rq.city_b] = rq.road_length;
               pair_dist[rq.city_b][rq.city_a] = rq.road_length;
            end
         end
         CmdClear: begin
            foreach (road_degree[i]) road_degree[i] = 0;
         end
         CmdQuery: begin
            queries_seen++;
            found = 1'b0;
            depth = 0;
            if (rq.city_a < limit && rq.city_b < limit) begin
               foreach (seen[i]) seen[i] = 1'b0;
               path_city[0] = rq.city_a;
               path_cursor[0] = 0;
               seen[rq.city_a] = 1'b1;
               depth = 1;
               found = (rq.city_a == rq.city_b);
               while (depth > 0 && !found) begin
                  top = depth - 1;
                  node = path_city[top];
                  idx = path_cursor[top];
                  moved = 1'b0;
                  while (idx < road_degree[node] && !moved) begin
                     nb = road_dest[node][idx];
                     idx++;
                     if (road_len[node][idx-1] <= rq.tank_capacity && !seen[nb]) begin
                        path_cursor[top] = idx;
                        if (depth < MaxCities) begin
                           path_city[depth] = nb;
                           path_cursor[depth] = 0;
                           seen[nb] = 1'b1;
                           depth++;
                           moved = 1'b1;
                           found = (nb == rq.city_b);
                        end
                     end
                  end
                  if (!moved) depth--;
               end
            end
            if (!found) begin
               impossible_seen++;
               step = '{1'b0, 7'd0, 6'd0, 1'b1};
               expected_steps = {expected_steps, step};
            end else begin
               paths_found++;
               // Greedy refuelling along the path, starting with one fill.
               fills = 1;
               fuel = rq.tank_capacity;
               for (k = 0; k + 1 < depth; k++) begin
                  hop = pair_dist[path_city[k]][path_city[k+1]];
                  fuel -= hop;
                  if (fuel < 0) begin
                     fuel = longint'(rq.tank_capacity) - hop;
                     if (fills < 127) fills++;
                  end
               end
               if (fuel < 0 && fills < 127) fills++;
               for (k = 0; k < depth; k++) begin
                  step = '{1'b1, 7'(fills), 6'(path_city[k]), (k + 1 == depth)};
                  expected_steps = {expected_steps, step};
               end
            end
         end
         default: ;
      endcase
   endtask

   // Sample both channels and the register port; check results in order.
   always @(posedge clock) begin
      path_step_type want;
      if (!reset) begin
         if (csr_we) cities_in_use = csr_wdata;
         if (req_valid && !req_stall) begin
            predict_request(road_request_type'{req_cmd, req_city_a, req_city_b,
                                               req_road_length, req_tank_capacity});
            req_accepts++;
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_accepts++;
            if (expected_steps.size() == 0) begin
               $error("unexpected result: city %0d last %0b", rsp_city, rsp_last);
               mismatches++;
            end else begin
               want = expected_steps.pop_front();
               if (rsp_possible !== want.possible) begin
                  $error("possible: expected %0b actual %0b", want.possible, rsp_possible);
                  mismatches++;
               end
               if (rsp_refills !== want.refills) begin
                  $error("refills: expected %0d actual %0d", want.refills, rsp_refills);
                  mismatches++;
               end
               if (rsp_city !== want.city) begin
                  $error("city: expected %0d actual %0d", want.city, rsp_city);
                  mismatches++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b actual %0b", want.last, rsp_last);
                  mismatches++;
               end
            end
         end
         // Watchdog: give up after a long stretch with no handshake at all.
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WatchLimit) begin
            $display("watchdog expired, %0d results still pending", expected_steps.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Request driver: hold while stalled, advance after each accept.
   int req_seen, req_gap, req_calm;
   always @(negedge clock) begin
      road_request_type nxt;
      if (reset) begin
         req_valid         <= 1'b0;
         req_cmd           <= CmdAdd;
         req_city_a        <= '0;
         req_city_b        <= '0;
         req_road_length   <= '0;
         req_tank_capacity <= '0;
      end else if (req_valid && req_seen == req_accepts) begin
         // hold the stalled request
      end else begin
         req_seen = req_accepts;
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            nxt = pending_requests.pop_front();
            req_valid         <= 1'b1;
            req_cmd           <= nxt.cmd;
            req_city_a        <= nxt.city_a;
            req_city_b        <= nxt.city_b;
            req_road_length   <= nxt.road_length;
            req_tank_capacity <= nxt.tank_capacity;
            req_calm = (req_calm + 1) % 48;
            req_gap = (req_calm < 12) ? 0 : $urandom_range(0, 6);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side: per-result wait, calm stretches, and long parks on request.
   int rsp_seen, rsp_wait, rsp_calm, park_left;
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (park_served != park_requests) begin
            park_served++;
            park_left = ParkCycles;
         end
         if (rsp_seen != rsp_accepts) begin
            rsp_seen = rsp_accepts;
            rsp_calm = (rsp_calm + 1) % 64;
            rsp_wait = (rsp_calm < 16) ? 0 : $urandom_range(0, 6);
         end
         if (park_left > 0) begin
            park_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic push_request(input cmd_type c, input int a, input int b,
                               input int len, input int cap);
      road_request_type rq;
      rq = '{c, 6'(a), 6'(b), 16'(len), 16'(cap)};
      pending_requests = {pending_requests, rq};
   endtask

   // Wait until every request is out and every result is back.
   task automatic wait_drained();
      while (pending_requests.size() > 0 || req_valid || expected_steps.size() > 0)
         @(posedge clock);
      repeat (DrainGap) @(posedge clock);
   endtask

   task automatic write_city_count(input int value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= 7'(value);
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Random city, mostly inside a small cluster so that paths exist.
   function automatic int pick_city(input int span);
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 63);
      return $urandom_range(0, span - 1);
   endfunction

   task automatic push_random(input int span);
      int pick, len, cap;
      pick = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 200) : $urandom_range(0, 65535);
      cap = ($urandom_range(0, 9) < 7) ? $urandom_range(50, 400) : $urandom_range(0, 65535);
      if (pick < 58)      push_request(CmdAdd, pick_city(span), pick_city(span), len, cap);
      else if (pick < 95) push_request(CmdQuery, pick_city(span), pick_city(span), len, cap);
      else if (pick < 98) push_request(CmdClear, pick_city(span), pick_city(span), len, cap);
      else                push_request(CmdUnused, pick_city(span), pick_city(span), len, cap);
   endtask

   initial begin
      int settings [5];
      int p, n, span;
      settings = '{1, 12, 64, 40, 7};
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = 7'd0;
      cities_in_use = 64;
      foreach (road_degree[i]) road_degree[i] = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: extremes, every command, full list, self road, refills.
      push_request(CmdAdd, 0, 1, 0, 0);
      push_request(CmdAdd, 1, 2, 65535, 0);
      push_request(CmdAdd, 0, 2, 100, 0);
      push_request(CmdAdd, 63, 62, 5, 0);
      push_request(CmdAdd, 5, 5, 1, 0);
      push_request(CmdQuery, 0, 2, 0, 65535);
      push_request(CmdQuery, 0, 2, 65535, 100);
      push_request(CmdQuery, 0, 2, 0, 0);
      push_request(CmdQuery, 3, 3, 0, 0);
      push_request(CmdQuery, 5, 5, 0, 0);
      push_request(CmdQuery, 0, 63, 0, 65535);
      push_request(CmdQuery, 63, 62, 0, 5);
      push_request(CmdUnused, 63, 63, 65535, 65535);
      push_request(CmdAdd, 30, 31, 60, 0);
      push_request(CmdAdd, 31, 32, 60, 0);
      push_request(CmdQuery, 30, 32, 0, 100);
      // overflow the list of city 10; the last road survives only at city 27
      for (n = 11; n <= 27; n++) push_request(CmdAdd, 10, n, n, 0);
      push_request(CmdQuery, 27, 10, 0, 65535);
      push_request(CmdQuery, 10, 27, 0, 65535);
      push_request(CmdClear, 0, 0, 0, 0);
      push_request(CmdQuery, 0, 1, 0, 65535);
      wait_drained();

      for (p = 0; p < 5; p++) begin
         write_city_count(settings[p]);
         span = (settings[p] < 10) ? settings[p] : 10;
         for (n = 0; n < 48; n++) begin
            push_random(span);
            if (n == 20 && (p == 1 || p == 3)) begin
               // park the result side while requests keep coming
               park_requests++;
               for (int j = 0; j < 6; j++)
                  push_request(CmdQuery, pick_city(span), pick_city(span), 0,
                               $urandom_range(100, 65535));
            end
            if (n == 40 && p == 2) wait_drained();
         end
         wait_drained();
      end
      write_city_count(64);

      $display("covered %0d requests, %0d roads stored, %0d queries", req_accepts,
               roads_seen, queries_seen);
      $display("queries with a path %0d, impossible %0d, results checked %0d",
               paths_found, impossible_seen, rsp_accepts);
      if (mismatches == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
